/* hdl/calp_pkg.sv */
// Shared types and constants for the calibrated line position block.
`default_nettype none
package calp_pkg;

  localparam int OP_W    = 2;
  localparam int CH_W    = 4;
  localparam int RAW_W   = 10;
  localparam int VALUE_W = 10;
  localparam int POS_W   = 14;
  localparam int VSUM_W  = 14;
  localparam int WSUM_W  = 28;

  localparam logic [OP_W-1:0] OP_CALIBRATE = 2'd0;
  localparam logic [OP_W-1:0] OP_MEASURE   = 2'd1;
  localparam logic [OP_W-1:0] OP_RESET     = 2'd2;

  localparam logic [VALUE_W-1:0] FULL_SCALE      = 10'd1000;
  localparam logic [VALUE_W-1:0] THRESHOLD_RESET = 10'd50;
  localparam logic [POS_W-1:0]   POSITION_RESET  = 14'd3500;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_READ = 7'b0000010,
    S_MUL  = 7'b0000100,
    S_DIV  = 7'b0001000,
    S_ACC  = 7'b0010000,
    S_END  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

endpackage
`default_nettype wire

/* hdl/calibrated_line_position.sv */
// Top level: per-channel calibration memory, serial divider and line position accumulator.
//
//  channel   direction  handshake               payload
//  in        sink       in_valid / in_ready     operation, channel, raw_sample, last_channel
//  out       source     out_valid / out_ready   calibrated_value, position, position_valid, on_line
//  cfg       sink       cfg_write               cfg_data (line_threshold)
//
// One request at a time. Calibrate goes through S_READ; channel reset is done in S_IDLE.
// Measure goes through the shared restoring divider (10 steps), and bypasses it when the
// sample is at or outside the calibrated range or the range is empty.
// A scan end with the line seen adds the 28-step position division.
// Reset clears the per-channel valid bits at once; no clearing pass is needed.
// A finished result waits in the output register; the next request is taken meanwhile
// and stalls only when it has its own result ready and out_ready is still low.
`default_nettype none
module calibrated_line_position #(
  parameter int CHANNELS   = 16,
  parameter int SAMPLE_MAX = 1023
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [calp_pkg::OP_W-1:0]     operation,
  input  logic [calp_pkg::CH_W-1:0]     channel,
  input  logic [calp_pkg::RAW_W-1:0]    raw_sample,
  input  logic                          last_channel,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [calp_pkg::VALUE_W-1:0]  calibrated_value,
  output logic [calp_pkg::POS_W-1:0]    position,
  output logic                          position_valid,
  output logic                          on_line,
  input  logic                          cfg_write,
  input  logic [calp_pkg::VALUE_W-1:0]  cfg_data
);
  import calp_pkg::*;

  localparam int SW    = $clog2(SAMPLE_MAX + 1);
  localparam int CW    = (SW > RAW_W) ? SW : RAW_W;
  localparam int IW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int NUM_W = SW + VALUE_W;
  localparam int DVW   = WSUM_W;
  localparam int DSW   = (VSUM_W > SW) ? VSUM_W : SW;
  localparam int CNT_W = $clog2(DVW + 1);

  state_t state;

  logic [VALUE_W-1:0] line_threshold;

  // calibration store: {minimum, maximum}; an entry not valid reads as the reset pair
  logic [2*SW-1:0]     cal_mem [CHANNELS];
  logic [CHANNELS-1:0] cal_valid;
  logic [2*SW-1:0]     rd_entry;
  logic                rd_valid;

  logic [OP_W-1:0]  item_op;
  logic [IW-1:0]    item_idx;
  logic [CH_W-1:0]  item_ch;
  logic [SW-1:0]    item_raw;
  logic             item_last;

  logic [VALUE_W-1:0] val;
  logic [NUM_W-1:0]   scaled_num;

  logic [DSW-1:0]     div_rem;
  logic [DVW-1:0]     div_q;
  logic [DSW-1:0]     div_d;
  logic [CNT_W-1:0]   div_cnt;
  logic               div_pos;

  logic [WSUM_W-1:0]  weighted_sum;
  logic [VSUM_W-1:0]  value_sum;
  logic               line_seen;
  logic [POS_W-1:0]   held_position;

  logic [IW-1:0]      in_idx;
  logic               in_take;
  logic               in_used;
  logic [CW-1:0]      raw_w;
  logic [SW-1:0]      raw_c;
  logic [SW-1:0]      lo;
  logic [SW-1:0]      hi;
  logic [DSW:0]       rem_sh;
  logic               rem_ge;
  logic [CH_W+VALUE_W-1:0] val_ch;
  logic [WSUM_W-1:0]  weighted_scaled;
  logic               out_free;

  assign in_ready = (state == S_IDLE);
  assign in_take  = in_valid && in_ready;
  assign in_idx   = channel[IW-1:0];
  assign in_used  = ({28'd0, channel} < 32'(CHANNELS)) &&
                    ((operation == OP_CALIBRATE) || (operation == OP_MEASURE) ||
                     (operation == OP_RESET));
  assign out_free = !out_valid || out_ready;

  always_comb begin
    raw_w = CW'(raw_sample);
    if (raw_w > CW'(SAMPLE_MAX)) begin
      raw_w = CW'(SAMPLE_MAX);
    end
    raw_c = raw_w[SW-1:0];
  end

  always_comb begin
    if (rd_valid) begin
      lo = rd_entry[2*SW-1:SW];
      hi = rd_entry[SW-1:0];
    end else begin
      lo = SW'(SAMPLE_MAX);
      hi = '0;
    end
  end

  // one restoring division step
  assign rem_sh = {div_rem, div_q[DVW-1]};
  assign rem_ge = (rem_sh >= {1'b0, div_d});

  assign val_ch          = val * item_ch;
  assign weighted_scaled = weighted_sum * WSUM_W'(FULL_SCALE);

  always_ff @(posedge clk) begin
    rd_entry <= cal_mem[in_idx];
    rd_valid <= cal_valid[in_idx];
    if (state == S_READ && item_op == OP_CALIBRATE) begin
      cal_mem[item_idx] <= {((item_raw < lo) ? item_raw : lo),
                            ((item_raw > hi) ? item_raw : hi)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_threshold <= THRESHOLD_RESET;
    end else if (cfg_write) begin
      line_threshold <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      cal_valid      <= '0;
      weighted_sum   <= '0;
      value_sum      <= '0;
      line_seen      <= 1'b0;
      held_position  <= POSITION_RESET;
      out_valid      <= 1'b0;
    end else begin
      // in S_OUT the output register is refilled instead
      if (out_valid && out_ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_take && in_used) begin
            item_op   <= operation;
            item_idx  <= in_idx;
            item_ch   <= channel;
            item_raw  <= raw_c;
            item_last <= last_channel;
            if (operation == OP_RESET) begin
              cal_valid[in_idx] <= 1'b0;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          if (item_op == OP_CALIBRATE) begin
            cal_valid[item_idx] <= 1'b1;
            state <= S_IDLE;
          end else if (hi <= lo || item_raw <= lo) begin
            val   <= '0;
            state <= S_ACC;
          end else if (item_raw >= hi) begin
            val   <= FULL_SCALE;
            state <= S_ACC;
          end else begin
            scaled_num <= (item_raw - lo) * NUM_W'(FULL_SCALE);
            div_d      <= DSW'(hi - lo);
            state      <= S_MUL;
          end
        end
        S_MUL: begin
          // quotient is below 1000 here, so only its low VALUE_W bits need steps
          div_rem <= DSW'(scaled_num[NUM_W-1:VALUE_W]);
          div_q   <= {scaled_num[VALUE_W-1:0], {(DVW-VALUE_W){1'b0}}};
          div_cnt <= CNT_W'(VALUE_W);
          div_pos <= 1'b0;
          state   <= S_DIV;
        end
        S_DIV: begin
          if (rem_ge) begin
            div_rem <= DSW'(rem_sh - {1'b0, div_d});
          end else begin
            div_rem <= rem_sh[DSW-1:0];
          end
          div_q   <= {div_q[DVW-2:0], rem_ge};
          div_cnt <= div_cnt - 1'b1;
          if (div_cnt == CNT_W'(1)) begin
            if (div_pos) begin
              held_position <= {div_q[POS_W-2:0], rem_ge};
              state         <= S_OUT;
            end else begin
              val   <= {div_q[VALUE_W-2:0], rem_ge};
              state <= S_ACC;
            end
          end
        end
        S_ACC: begin
          if (val > line_threshold) begin
            line_seen    <= 1'b1;
            value_sum    <= value_sum + VSUM_W'(val);
            weighted_sum <= weighted_sum + WSUM_W'(val_ch);
          end
          state <= S_END;
        end
        S_END: begin
          // weighted_sum holds the sum of value*channel; the x1000 is applied once here
          if (item_last && line_seen && value_sum != '0) begin
            div_rem <= '0;
            div_q   <= weighted_scaled;
            div_d   <= DSW'(value_sum);
            div_cnt <= CNT_W'(DVW);
            div_pos <= 1'b1;
            state   <= S_DIV;
          end else begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid        <= 1'b1;
            calibrated_value <= val;
            position_valid   <= item_last;
            on_line          <= item_last && line_seen;
            position         <= item_last ? held_position : '0;
            if (item_last) begin
              weighted_sum <= '0;
              value_sum    <= '0;
              line_seen    <= 1'b0;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

/* verif/tb_top.sv */
// Testbench for calibrated_line_position: directed and random requests checked against a predictor.
`default_nettype none
module tb_top;
  import calp_pkg::*;

  localparam int HALF_PERIOD  = 6;
  localparam int RESET_CYCLES = 6;
  localparam int DRAIN_CYCLES = 80;       // covers a scan end with the 28-step division
  localparam int LIMIT_CYCLES = 800000;
  localparam int MAX_REPORTS  = 10;
  localparam int NUM_CH       = 16;
  localparam int unsigned RAW_TOP = 1023;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [POS_W-1:0]   pos;
    logic               pos_valid;
    logic               line;
  } line_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [OP_W-1:0]    operation = OP_CALIBRATE;
  logic [CH_W-1:0]    channel = '0;
  logic [RAW_W-1:0]   raw_sample = '0;
  logic               last_channel = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [VALUE_W-1:0] calibrated_value;
  logic [POS_W-1:0]   position;
  logic               position_valid;
  logic               on_line;
  logic               cfg_write = 1'b0;
  logic [VALUE_W-1:0] cfg_data = '0;

  // predictor state
  int unsigned        cal_min [NUM_CH];
  int unsigned        cal_max [NUM_CH];
  logic [WSUM_W-1:0]  weight_sum;
  logic [VSUM_W-1:0]  value_sum;
  logic               line_seen;
  logic [POS_W-1:0]   held_pos;
  logic [VALUE_W-1:0] threshold;

  line_result_t pending_results[$];
  int mismatches = 0;
  int send_pct = 0;
  int stall_pct = 0;
  int hold_cycles = 0;

  calibrated_line_position i_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .operation        (operation),
    .channel          (channel),
    .raw_sample       (raw_sample),
    .last_channel     (last_channel),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .calibrated_value (calibrated_value),
    .position         (position),
    .position_valid   (position_valid),
    .on_line          (on_line),
    .cfg_write        (cfg_write),
    .cfg_data         (cfg_data)
  );

  always #(HALF_PERIOD) clk = ~clk;

  function automatic int unsigned scaled_value(int unsigned raw, int unsigned lo,
                                               int unsigned hi);
    int unsigned q;
    if (hi <= lo || raw <= lo) return 0;
    q = (raw - lo) * int'(FULL_SCALE) / (hi - lo);
    return (q > int'(FULL_SCALE)) ? int'(FULL_SCALE) : q;
  endfunction

  task automatic predict_line_result(input logic [OP_W-1:0] op, input logic [CH_W-1:0] ch,
                                     input logic [RAW_W-1:0] raw, input logic last);
    int unsigned  val;
    line_result_t r;
    if (op == OP_CALIBRATE) begin
      if (raw < cal_min[ch]) cal_min[ch] = raw;
      if (raw > cal_max[ch]) cal_max[ch] = raw;
    end else if (op == OP_RESET) begin
      cal_min[ch] = RAW_TOP;
      cal_max[ch] = 0;
    end else if (op == OP_MEASURE) begin
      val = scaled_value(raw, cal_min[ch], cal_max[ch]);
      if (val > threshold) begin
        line_seen  = 1'b1;
        weight_sum = weight_sum + WSUM_W'(val * int'(ch) * int'(FULL_SCALE));
        value_sum  = value_sum + VSUM_W'(val);
      end
      r.value     = VALUE_W'(val);
      r.pos       = '0;
      r.pos_valid = 1'b0;
      r.line      = 1'b0;
      if (last) begin
        if (line_seen && value_sum != 0) held_pos = POS_W'(weight_sum / value_sum);
        r.pos       = held_pos;
        r.pos_valid = 1'b1;
        r.line      = line_seen;
        weight_sum  = '0;
        value_sum   = '0;
        line_seen   = 1'b0;
      end
      pending_results.push_back(r);
    end
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("mismatch on %s: expected %0d, got %0d", name, want, got);
    end
  endtask

  always @(posedge clk) begin
    line_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: value %0d position %0d", calibrated_value, position);
      end else begin
        want = pending_results.pop_front();
        check_field("calibrated_value", want.value, calibrated_value);
        check_field("position", want.pos, position);
        check_field("position_valid", want.pos_valid, position_valid);
        check_field("on_line", want.line, on_line);
      end
    end
  end

  // receiver: random stalls, or a counted hold-off when one is armed
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles--;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_request(input logic [OP_W-1:0] op, input int unsigned ch,
                              input int unsigned raw, input logic last);
    @(negedge clk);
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    operation    <= op;
    channel      <= CH_W'(ch);
    raw_sample   <= RAW_W'(raw);
    last_channel <= last;
    do @(posedge clk); while (!in_ready);
    predict_line_result(op, CH_W'(ch), RAW_W'(raw), last);
  endtask

  // drop valid, let every expected result arrive, then allow for a trailing request
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [VALUE_W-1:0] value);
    wait_idle();
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    threshold = value;
  endtask

  function automatic int unsigned random_raw();
    case ($urandom_range(7))
      0: return 0;
      1: return RAW_TOP;
      default: return $urandom_range(RAW_TOP);
    endcase
  endfunction

  // one measure pass over channels 0..count-1, last mark on the final one
  task automatic send_scan(input int count, inout int sent);
    for (int c = 0; c < count; c++) begin
      send_request(OP_MEASURE, c, random_raw(), c == count - 1);
      sent++;
    end
  endtask

  task automatic test_directed();
    send_request(OP_MEASURE, 0, 0, 1'b0);          // no calibration yet
    send_request(OP_CALIBRATE, 0, 100, 1'b0);
    send_request(OP_CALIBRATE, 0, 900, 1'b1);      // last mark on calibrate is ignored
    send_request(OP_MEASURE, 0, 50, 1'b0);         // below minimum
    send_request(OP_MEASURE, 0, 1023, 1'b0);       // above maximum, saturates
    send_request(OP_MEASURE, 0, 500, 1'b0);
    send_request(OP_UNUSED, 5, 1023, 1'b1);        // dropped
    send_request(OP_CALIBRATE, 15, 0, 1'b0);
    send_request(OP_CALIBRATE, 15, 1023, 1'b0);
    send_request(OP_MEASURE, 15, 1023, 1'b1);      // scan end, far edge
    send_request(OP_MEASURE, 3, 700, 1'b1);        // nothing on the line: held position
    send_request(OP_RESET, 0, 0, 1'b1);
    send_request(OP_MEASURE, 0, 500, 1'b1);
    send_request(OP_CALIBRATE, 7, 512, 1'b0);      // min equals max
    send_request(OP_MEASURE, 7, 512, 1'b0);
    send_request(OP_MEASURE, 7, 1023, 1'b1);
    send_request(OP_CALIBRATE, 0, 0, 1'b0);
    send_request(OP_MEASURE, 0, 1023, 1'b0);
    send_request(OP_MEASURE, 15, 1023, 1'b1);      // only channel 15 on the line; channel 0 has min equal to max
    wait_idle();
  endtask

  task automatic test_threshold_extremes();
    logic [VALUE_W-1:0] levels [4];
    int sent;
    levels = '{10'd0, 10'd1000, 10'd1023, 10'd50};
    sent = 0;
    for (int c = 0; c < NUM_CH; c++) begin
      send_request(OP_CALIBRATE, c, $urandom_range(200), 1'b0);
      send_request(OP_CALIBRATE, c, $urandom_range(800, RAW_TOP), 1'b0);
    end
    foreach (levels[i]) begin
      write_threshold(levels[i]);
      send_scan(NUM_CH, sent);
      send_scan($urandom_range(1, 4), sent);
    end
    wait_idle();
  endtask

  task automatic test_random_traffic(input int items, input int idle_pct, input int hold_pct);
    int sent;
    int count;
    logic [OP_W-1:0] op;
    sent = 0;
    write_threshold(VALUE_W'($urandom_range(FULL_SCALE)));
    send_pct  = idle_pct;
    stall_pct = hold_pct;
    while (sent < items) begin
      case ($urandom_range(9))
        0, 1: begin
          // noise: any code, any channel, any mark
          op = OP_W'($urandom_range(3));
          send_request(op, $urandom_range(NUM_CH - 1), $urandom(), 1'($urandom_range(1)));
          if (op != OP_UNUSED) sent++;
        end
        2, 3: begin
          count = $urandom_range(1, NUM_CH);
          for (int c = 0; c < count; c++) begin
            if ($urandom_range(3) == 0) begin
              send_request(OP_RESET, c, $urandom(), 1'b0);
              sent++;
            end
            send_request(OP_CALIBRATE, c, random_raw(), 1'b0);
            send_request(OP_CALIBRATE, c, random_raw(), 1'b0);
            sent += 2;
          end
        end
        default: send_scan($urandom_range(1, NUM_CH), sent);
      endcase
    end
    wait_idle();
    send_pct  = 0;
    stall_pct = 0;
  endtask

  // receiver holds off while the sender keeps going, so the input backs up
  task automatic test_output_stall();
    int sent;
    sent = 0;
    hold_cycles = 600;
    send_scan(NUM_CH, sent);
    send_scan(NUM_CH, sent);
    send_scan(8, sent);
    wait_idle();
  endtask

  initial begin
    #(LIMIT_CYCLES * 2 * HALF_PERIOD);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    for (int c = 0; c < NUM_CH; c++) begin
      cal_min[c] = RAW_TOP;
      cal_max[c] = 0;
    end
    weight_sum = '0;
    value_sum  = '0;
    line_seen  = 1'b0;
    held_pos   = POSITION_RESET;
    threshold  = THRESHOLD_RESET;

    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_threshold_extremes();
    test_random_traffic(280, 0, 0);
    test_random_traffic(280, 82, 0);
    test_random_traffic(280, 0, 82);
    test_random_traffic(280, 17, 17);
    test_output_stall();

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
